### rtl/core/dhlt_pkg.sv
// Package for the DH link point transform: widths, types and the CORDIC arctangent table.
package dhlt_pkg;

  localparam int AngleBits   = 16;
  localparam int CoordBits   = 32;
  localparam int FracBits    = 16;
  localparam int TrigShift   = 30;
  localparam int CordicSteps = 30;
  localparam int TrigBits    = 34;   // sin/cos span about +/-2^30 with CORDIC headroom
  localparam int InBits      = 2 * AngleBits + 6 * CoordBits;
  localparam int OutBits     = 4 * CoordBits;

  localparam logic signed [TrigBits-1:0] CordicGain = TrigBits'(652032874);

  typedef logic signed [TrigBits-1:0]  trig_t;
  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [AngleBits-1:0] angle_t;

  typedef struct packed {
    angle_t joint_angle;
    angle_t link_twist;
    coord_t link_offset;
    coord_t link_length;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t point_w;
  } item_t;

  function automatic logic signed [32:0] atan_entry(input int i);
    logic signed [32:0] r;
    unique case (i)
      0: r = 33'sd536870912;   1: r = 33'sd316933406;   2: r = 33'sd167458907;
      3: r = 33'sd85004756;    4: r = 33'sd42667331;    5: r = 33'sd21354465;
      6: r = 33'sd10679838;    7: r = 33'sd5340245;     8: r = 33'sd2670163;
      9: r = 33'sd1335087;     10: r = 33'sd667544;     11: r = 33'sd333772;
      12: r = 33'sd166886;     13: r = 33'sd83443;      14: r = 33'sd41722;
      15: r = 33'sd20861;      16: r = 33'sd10430;      17: r = 33'sd5215;
      18: r = 33'sd2608;       19: r = 33'sd1304;       20: r = 33'sd652;
      21: r = 33'sd326;        22: r = 33'sd163;        23: r = 33'sd81;
      24: r = 33'sd41;         25: r = 33'sd20;         26: r = 33'sd10;
      27: r = 33'sd5;          28: r = 33'sd3;          29: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round(p >> sh) half away from zero on a sign-magnitude basis, clamp magnitude to 2^62
  function automatic logic signed [65:0] round_shift(input logic signed [97:0] p,
                                                      input int sh);
    logic        neg;
    logic [97:0] mag;
    logic [97:0] q;
    logic signed [65:0] r;
    neg = p[97];
    mag = neg ? 98'(-p) : 98'(p);
    q   = (mag + (98'd1 << (sh - 1))) >> sh;
    if (q > (98'd1 << 62)) q = 98'd1 << 62;
    r = neg ? -$signed({1'b0, q[64:0]}) : $signed({1'b0, q[64:0]});
    return r;
  endfunction

  function automatic coord_t sat_coord(input logic signed [67:0] v);
    coord_t r;
    if (v > 68'sd2147483647) r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[CoordBits-1:0];
    return r;
  endfunction

endpackage

### rtl/core/dhlt_cordic.sv
// Pipelined CORDIC that gives sin and cos of one binary angle per cycle while en is high.
module dhlt_cordic (
  input  logic                  clk,
  input  logic                  en,
  input  dhlt_pkg::angle_t      angle,
  output dhlt_pkg::trig_t       sin_out,
  output dhlt_pkg::trig_t       cos_out
);
  import dhlt_pkg::*;

  trig_t              x [0:CordicSteps];
  trig_t              y [0:CordicSteps];
  logic signed [32:0] z [0:CordicSteps];
  logic               flip [0:CordicSteps];

  logic signed [32:0] phase;
  logic               fold;

  always_comb begin
    phase = 33'($signed({angle, {(32 - AngleBits){1'b0}}}));
    fold  = (phase > 33'sd1073741824) || (phase < -33'sd1073741824);
  end

  // stage 0: fold into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CordicGain;
      y[0]    <= '0;
      flip[0] <= fold;
      if (!fold) z[0] <= phase;
      else if (phase > 0) z[0] <= phase - 33'sd2147483648;
      else z[0] <= phase + 33'sd2147483648;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_entry(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_entry(i);
        end
      end
    end
  end

  assign cos_out = flip[CordicSteps] ? -x[CordicSteps] : x[CordicSteps];
  assign sin_out = flip[CordicSteps] ? -y[CordicSteps] : y[CordicSteps];

endmodule

### rtl/core/dh_link_point_transform.sv
// Top level of the DH link point transform pipeline.
// Pipeline: 31 CORDIC stages and 4 product/sum stages between input transaction and result.
// Throughput: one transaction per cycle; the whole pipeline advances together and holds
// when the output stage is full and not taken.
// Reset: rst (synchronous, active high) clears all valid bits; payload is not reset.
module dh_link_point_transform (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // joint_angle, link_twist, link_offset, link_length, point_x, point_y, point_z, point_w
  input  logic [dhlt_pkg::InBits-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_x, out_y, out_z, out_w
  output logic [dhlt_pkg::OutBits-1:0] m_axis_tdata
);
  import dhlt_pkg::*;

  localparam int Depth = CordicSteps + 5;

  logic en;
  logic [Depth-1:0] vld;

  // advance whenever the last stage is empty or being taken
  assign en            = !vld[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], s_axis_tvalid};
  end

  item_t in_item;
  always_comb begin
    in_item.joint_angle = s_axis_tdata[AngleBits-1:0];
    in_item.link_twist  = s_axis_tdata[2*AngleBits-1:AngleBits];
    in_item.link_offset = s_axis_tdata[2*AngleBits+CoordBits-1:2*AngleBits];
    in_item.link_length = s_axis_tdata[2*AngleBits+2*CoordBits-1:2*AngleBits+CoordBits];
    in_item.point_x     = s_axis_tdata[2*AngleBits+3*CoordBits-1:2*AngleBits+2*CoordBits];
    in_item.point_y     = s_axis_tdata[2*AngleBits+4*CoordBits-1:2*AngleBits+3*CoordBits];
    in_item.point_z     = s_axis_tdata[2*AngleBits+5*CoordBits-1:2*AngleBits+4*CoordBits];
    in_item.point_w     = s_axis_tdata[2*AngleBits+6*CoordBits-1:2*AngleBits+5*CoordBits];
  end

  trig_t st, ct, sa, ca;
  dhlt_cordic u_theta (.clk, .en, .angle(in_item.joint_angle), .sin_out(st), .cos_out(ct));
  dhlt_cordic u_alpha (.clk, .en, .angle(in_item.link_twist),  .sin_out(sa), .cos_out(ca));

  // delay line for the coordinates alongside the CORDIC
  item_t dly [0:CordicSteps];
  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= in_item;
      for (int i = 1; i <= CordicSteps; i++) dly[i] <= dly[i-1];
    end
  end

  // stage A: trig registered, trig*trig products and a*w, d*w
  // trig*trig products stay within about 2^30, so the trig width holds them
  trig_t  a_st, a_ct, a_sa, a_ca;
  trig_t  a_stca, a_stsa, a_ctca, a_ctsa;
  coord_t a_aw, a_dw, a_x, a_y, a_z, a_w;
  always_ff @(posedge clk) begin
    if (en) begin
      a_st <= st; a_ct <= ct; a_sa <= sa; a_ca <= ca;
      a_stca <= trig_t'(round_shift(98'(st * ca), TrigShift));
      a_stsa <= trig_t'(round_shift(98'(st * sa), TrigShift));
      a_ctca <= trig_t'(round_shift(98'(ct * ca), TrigShift));
      a_ctsa <= trig_t'(round_shift(98'(ct * sa), TrigShift));
      a_aw <= sat_coord(68'(round_shift(98'(dly[CordicSteps].link_length
                                          * dly[CordicSteps].point_w), FracBits)));
      a_dw <= sat_coord(68'(round_shift(98'(dly[CordicSteps].link_offset
                                          * dly[CordicSteps].point_w), FracBits)));
      a_x <= dly[CordicSteps].point_x; a_y <= dly[CordicSteps].point_y;
      a_z <= dly[CordicSteps].point_z; a_w <= dly[CordicSteps].point_w;
    end
  end

  // stage B: trig-times-coordinate terms
  logic signed [65:0] b_t [0:9];
  coord_t b_dw, b_w;
  always_ff @(posedge clk) begin
    if (en) begin
      b_t[0]  <= round_shift(98'(a_ct * a_x), TrigShift);
      b_t[1]  <= round_shift(98'(a_stca * a_y), TrigShift);
      b_t[2]  <= round_shift(98'(a_stsa * a_z), TrigShift);
      b_t[3]  <= round_shift(98'(a_ct * a_aw), TrigShift);
      b_t[4]  <= round_shift(98'(a_st * a_x), TrigShift);
      b_t[5]  <= round_shift(98'(a_ctca * a_y), TrigShift);
      b_t[6]  <= round_shift(98'(a_ctsa * a_z), TrigShift);
      b_t[7]  <= round_shift(98'(a_st * a_aw), TrigShift);
      b_t[8]  <= round_shift(98'(a_sa * a_y), TrigShift);
      b_t[9]  <= round_shift(98'(a_ca * a_z), TrigShift);
      b_dw <= a_dw; b_w <= a_w;
    end
  end

  // stage C: pairwise sums, with d*w passed through for z
  logic signed [67:0] c_x0, c_x1, c_y0, c_y1, c_z0, c_z1;
  coord_t c_w;
  always_ff @(posedge clk) begin
    if (en) begin
      c_x0 <= 68'(b_t[0]) - 68'(b_t[1]);
      c_x1 <= 68'(b_t[2]) + 68'(b_t[3]);
      c_y0 <= 68'(b_t[4]) + 68'(b_t[5]);
      c_y1 <= 68'(b_t[7]) - 68'(b_t[6]);
      c_z0 <= 68'(b_t[8]) + 68'(b_t[9]);
      c_z1 <= 68'(b_dw);
      c_w  <= b_w;
    end
  end

  // stage D: final sum and saturate
  coord_t d_x, d_y, d_z, d_w;
  always_ff @(posedge clk) begin
    if (en) begin
      d_x <= sat_coord(c_x0 + c_x1);
      d_y <= sat_coord(c_y0 + c_y1);
      d_z <= sat_coord(c_z0 + c_z1);
      d_w <= c_w;
    end
  end

  assign m_axis_tdata = {d_w, d_z, d_y, d_x};

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready inconsistent with output stage");
  a_shift: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted transaction lost at entry");

endmodule
